[hw/rtl/cpor_pkg.sv]
// cpor_pkg: widths, payload structs and saturation helper for the
// circle pair overlap resolver. No dependencies.
`default_nettype none

package cpor_pkg;

    localparam int POS_W    = 24;              // Q3.x position field
    localparam int RADIUS_W = 22;              // contact radius register
    localparam int DIFF_W   = POS_W + 1;       // separation / magnitude
    localparam int SQ_W     = 2 * DIFF_W;      // squared length
    localparam int ROOT_W   = SQ_W / 2;        // length
    localparam int PROD_W   = DIFF_W + RADIUS_W;
    localparam int DEN_W    = RADIUS_W + 1;    // 2 * length
    localparam int QUO_W    = RADIUS_W - 1;    // push never exceeds overlap / 2

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Positions of one pair and the signs of the separation
    typedef struct packed {
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
        logic                    neg_x;
        logic                    neg_y;
    } cpor_side_t;

    // Travels beside the square root
    typedef struct packed {
        cpor_side_t        side;
        logic [DIFF_W-1:0] ax;
        logic [DIFF_W-1:0] ay;
    } cpor_track_t;

    // Travels beside the divider
    typedef struct packed {
        cpor_side_t side;
        logic       hit;
    } cpor_post_t;

    // Clamp a sum of two positions to the field range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > $signed({{2{POS_MAX[POS_W-1]}}, POS_MAX}))
            r = POS_MAX;
        else if (v < $signed({{2{POS_MIN[POS_W-1]}}, POS_MIN}))
            r = POS_MIN;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cpor_pair_if.sv]
// cpor_pair_if / cpor_result_if: valid-ready channels for the resolver.
// Depends on cpor_pkg.
`default_nettype none

interface cpor_pair_if import cpor_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface cpor_result_if import cpor_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] new_first_x;
    logic signed [POS_W-1:0] new_first_y;
    logic signed [POS_W-1:0] new_second_x;
    logic signed [POS_W-1:0] new_second_y;
    logic                    collided;

    modport source (output valid, new_first_x, new_first_y, new_second_x, new_second_y,
                    collided, input ready);
    modport sink   (input valid, new_first_x, new_first_y, new_second_x, new_second_y,
                    collided, output ready);
endinterface

`default_nettype wire

[hw/rtl/cpor_isqrt.sv]
// cpor_isqrt: pipelined integer square root, one root bit per stage,
// with a sideband word carried alongside. Depends on cpor_pkg.
`default_nettype none

module cpor_isqrt import cpor_pkg::*; #(
    parameter int RAD_W = 50,
    parameter int SB_W  = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [RAD_W-1:0]     in_rad,
    input  wire logic [SB_W-1:0]      in_sb,
    output logic                      out_valid,
    output logic [RAD_W/2-1:0]        out_root,
    output logic [SB_W-1:0]           out_sb
);

    localparam int NB = RAD_W / 2;

    logic [RAD_W-1:0] rem_reg  [NB];
    logic [NB-1:0]    root_reg [NB];
    logic [SB_W-1:0]  sb_reg   [NB];
    logic [NB-1:0]    vld_reg;

    genvar k;
    generate
        for (k = 0; k < NB; k++)
        begin : g_stage
            localparam int BIT = NB - 1 - k;
            logic [RAD_W-1:0] rem_in;
            logic [NB-1:0]    root_in;
            logic [SB_W-1:0]  sb_in;
            logic             vld_in;
            logic [RAD_W:0]   trial;
            logic             take;
            logic [RAD_W-1:0] rem_next;
            logic [NB-1:0]    root_next;

            if (k == 0)
            begin : g_first
                assign rem_in  = in_rad;
                assign root_in = '0;
                assign sb_in   = in_sb;
                assign vld_in  = in_valid;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign sb_in   = sb_reg[k-1];
                assign vld_in  = vld_reg[k-1];
            end

            // trial = root * 2^(BIT+1) + 2^(2*BIT)
            always_comb
            begin
                trial = ({{(RAD_W+1-NB){1'b0}}, root_in} << (BIT + 1))
                      | ((RAD_W+1)'(1) << (2 * BIT));
                take  = ({1'b0, rem_in} >= trial);
                rem_next  = take ? (rem_in - trial[RAD_W-1:0]) : rem_in;
                root_next = take ? (root_in | (NB'(1) << BIT)) : root_in;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    sb_reg[k]   <= sb_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NB-1];
    assign out_root  = root_reg[NB-1];
    assign out_sb    = sb_reg[NB-1];

endmodule

`default_nettype wire

[hw/rtl/cpor_div.sv]
// cpor_div: pipelined restoring divider, two numerators over one shared
// divisor, one quotient bit per stage. Depends on cpor_pkg.
`default_nettype none

module cpor_div import cpor_pkg::*; #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 23,
    parameter int QB    = 21,
    parameter int SB_W  = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num_x,
    input  wire logic [NUM_W-1:0]  in_num_y,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SB_W-1:0]   in_sb,
    output logic                   out_valid,
    output logic [QB-1:0]          out_quo_x,
    output logic [QB-1:0]          out_quo_y,
    output logic [SB_W-1:0]        out_sb
);

    logic [NUM_W-1:0] rx_reg  [QB];
    logic [NUM_W-1:0] ry_reg  [QB];
    logic [QB-1:0]    qx_reg  [QB];
    logic [QB-1:0]    qy_reg  [QB];
    logic [DEN_W-1:0] den_reg [QB];
    logic [SB_W-1:0]  sb_reg  [QB];
    logic [QB-1:0]    vld_reg;

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_stage
            localparam int BIT = QB - 1 - k;
            logic [NUM_W-1:0] rx_in, ry_in;
            logic [QB-1:0]    qx_in, qy_in;
            logic [DEN_W-1:0] den_in;
            logic [SB_W-1:0]  sb_in;
            logic             vld_in;
            logic [NUM_W+DEN_W-1:0] dsh;
            logic             tx, ty;
            logic [NUM_W-1:0] rx_next, ry_next;
            logic [QB-1:0]    qx_next, qy_next;

            if (k == 0)
            begin : g_first
                assign rx_in  = in_num_x;
                assign ry_in  = in_num_y;
                assign qx_in  = '0;
                assign qy_in  = '0;
                assign den_in = in_den;
                assign sb_in  = in_sb;
                assign vld_in = in_valid;
            end
            else
            begin : g_rest
                assign rx_in  = rx_reg[k-1];
                assign ry_in  = ry_reg[k-1];
                assign qx_in  = qx_reg[k-1];
                assign qy_in  = qy_reg[k-1];
                assign den_in = den_reg[k-1];
                assign sb_in  = sb_reg[k-1];
                assign vld_in = vld_reg[k-1];
            end

            // compare partial remainders against divisor * 2^BIT
            always_comb
            begin
                dsh = {{NUM_W{1'b0}}, den_in} << BIT;
                tx  = ({{DEN_W{1'b0}}, rx_in} >= dsh);
                ty  = ({{DEN_W{1'b0}}, ry_in} >= dsh);
                rx_next = tx ? (rx_in - dsh[NUM_W-1:0]) : rx_in;
                ry_next = ty ? (ry_in - dsh[NUM_W-1:0]) : ry_in;
                qx_next = tx ? (qx_in | (QB'(1) << BIT)) : qx_in;
                qy_next = ty ? (qy_in | (QB'(1) << BIT)) : qy_in;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rx_reg[k]  <= rx_next;
                    ry_reg[k]  <= ry_next;
                    qx_reg[k]  <= qx_next;
                    qy_reg[k]  <= qy_next;
                    den_reg[k] <= den_in;
                    sb_reg[k]  <= sb_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QB-1];
    assign out_quo_x = qx_reg[QB-1];
    assign out_quo_y = qy_reg[QB-1];
    assign out_sb    = sb_reg[QB-1];

endmodule

`default_nettype wire

[hw/rtl/circle_pair_overlap_resolver.sv]
// Circle pair overlap resolver: takes one particle pair per cycle and returns the
// pair pushed apart by half the overlap along the separation, with a collided flag.
// Throughput is one transaction per clock while the result is taken. There are 3 front
// stages, 25 square-root stages at one root bit each, 2 stages for overlap and products,
// 21 divider stages at one quotient bit each and 1 output stage. The whole pipeline
// advances together, so when the result is not taken the input holds off too.
// Depends on cpor_pkg, cpor_pair_if, cpor_result_if, cpor_isqrt, cpor_div.
`default_nettype none

module circle_pair_overlap_resolver import cpor_pkg::*; #(
    parameter int COORD_FRAC_BITS = 20
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [RADIUS_W-1:0] cfg_wr_data,
    cpor_pair_if.sink                pair,
    cpor_result_if.source            result
);

    // reset radius = round(0.02 in the position scale)
    localparam longint unsigned RadOne = 64'd1 << COORD_FRAC_BITS;
    localparam longint unsigned RadRst = (RadOne * 2 + 50) / 100;

    logic [RADIUS_W-1:0] radius_reg;
    logic                en;

    // stage A: separation and magnitude
    logic              vld_a_reg;
    cpor_side_t        side_a_reg, side_a_next;
    logic [DIFF_W-1:0] ax_a_reg, ay_a_reg, ax_a_next, ay_a_next;
    logic signed [DIFF_W-1:0] dx, dy;

    // stage B: squares
    logic              vld_b_reg;
    cpor_track_t       trk_b_reg;
    logic [SQ_W-1:0]   sqx_b_reg, sqy_b_reg;

    // stage C: squared length
    logic              vld_c_reg;
    cpor_track_t       trk_c_reg;
    logic [SQ_W-1:0]   sum_c_reg;

    // square root output
    logic              vld_r;
    logic [ROOT_W-1:0] root_r;
    cpor_track_t       trk_r;

    // stage D: overlap test
    logic                vld_d_reg;
    cpor_track_t         trk_d_reg;
    logic                hit_d_reg, hit_d_next;
    logic [RADIUS_W-1:0] delta_d_reg, len_d_reg;

    // stage E: numerators and divisor
    logic              vld_e_reg;
    cpor_post_t        post_e_reg;
    logic [PROD_W-1:0] px_e_reg, py_e_reg;
    logic [DEN_W-1:0]  den_e_reg;

    // divider output
    logic              vld_q;
    logic [QUO_W-1:0]  qx, qy;
    cpor_post_t        post_q;

    // stage F: output register
    logic                    vld_f_reg;
    logic signed [POS_W-1:0] n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic signed [POS_W-1:0] n1x_next, n1y_next, n2x_next, n2y_next;
    logic                    hit_f_reg;
    logic signed [DIFF_W-1:0] sx, sy;

    assign en         = !vld_f_reg || result.ready;
    assign pair.ready = en;

    // contact radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_W'(RadRst);
        else if (cfg_wr_en)
            radius_reg <= cfg_wr_data;
    end

    // valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= pair.valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_r;
            vld_e_reg <= vld_d_reg;
            vld_f_reg <= vld_q;
        end
    end

    // stage A logic
    always_comb
    begin
        dx = {pair.first_x[POS_W-1], pair.first_x} - {pair.second_x[POS_W-1], pair.second_x};
        dy = {pair.first_y[POS_W-1], pair.first_y} - {pair.second_y[POS_W-1], pair.second_y};
        ax_a_next = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay_a_next = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        side_a_next.x1    = pair.first_x;
        side_a_next.y1    = pair.first_y;
        side_a_next.x2    = pair.second_x;
        side_a_next.y2    = pair.second_y;
        side_a_next.neg_x = dx[DIFF_W-1];
        side_a_next.neg_y = dy[DIFF_W-1];
    end

    // stage D logic: zero length counts as no contact
    always_comb
    begin
        hit_d_next = (root_r != '0) && (root_r < {{(ROOT_W-RADIUS_W){1'b0}}, radius_reg});
    end

    // stage F logic: signed push, apply and saturate
    always_comb
    begin
        sx = post_q.side.neg_x ? -$signed({{(DIFF_W-QUO_W){1'b0}}, qx})
                               :  $signed({{(DIFF_W-QUO_W){1'b0}}, qx});
        sy = post_q.side.neg_y ? -$signed({{(DIFF_W-QUO_W){1'b0}}, qy})
                               :  $signed({{(DIFF_W-QUO_W){1'b0}}, qy});
        if (post_q.hit)
        begin
            n1x_next = sat_pos({{2{post_q.side.x1[POS_W-1]}}, post_q.side.x1} + {sx[DIFF_W-1], sx});
            n1y_next = sat_pos({{2{post_q.side.y1[POS_W-1]}}, post_q.side.y1} + {sy[DIFF_W-1], sy});
            n2x_next = sat_pos({{2{post_q.side.x2[POS_W-1]}}, post_q.side.x2} - {sx[DIFF_W-1], sx});
            n2y_next = sat_pos({{2{post_q.side.y2[POS_W-1]}}, post_q.side.y2} - {sy[DIFF_W-1], sy});
        end
        else
        begin
            n1x_next = post_q.side.x1;
            n1y_next = post_q.side.y1;
            n2x_next = post_q.side.x2;
            n2y_next = post_q.side.y2;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg <= side_a_next;
            ax_a_reg   <= ax_a_next;
            ay_a_reg   <= ay_a_next;

            trk_b_reg.side <= side_a_reg;
            trk_b_reg.ax   <= ax_a_reg;
            trk_b_reg.ay   <= ay_a_reg;
            sqx_b_reg      <= ax_a_reg * ax_a_reg;
            sqy_b_reg      <= ay_a_reg * ay_a_reg;

            trk_c_reg <= trk_b_reg;
            sum_c_reg <= sqx_b_reg + sqy_b_reg;

            trk_d_reg   <= trk_r;
            hit_d_reg   <= hit_d_next;
            len_d_reg   <= root_r[RADIUS_W-1:0];
            delta_d_reg <= hit_d_next ? (radius_reg - root_r[RADIUS_W-1:0]) : '0;

            post_e_reg.side <= trk_d_reg.side;
            post_e_reg.hit  <= hit_d_reg;
            px_e_reg  <= trk_d_reg.ax * delta_d_reg;
            py_e_reg  <= trk_d_reg.ay * delta_d_reg;
            den_e_reg <= {len_d_reg, 1'b0};

            n1x_reg   <= n1x_next;
            n1y_reg   <= n1y_next;
            n2x_reg   <= n2x_next;
            n2y_reg   <= n2y_next;
            hit_f_reg <= post_q.hit;
        end
    end

    cpor_isqrt #(
        .RAD_W (SQ_W),
        .SB_W  ($bits(cpor_track_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_c_reg),
        .in_rad    (sum_c_reg),
        .in_sb     (trk_c_reg),
        .out_valid (vld_r),
        .out_root  (root_r),
        .out_sb    (trk_r)
    );

    cpor_div #(
        .NUM_W (PROD_W),
        .DEN_W (DEN_W),
        .QB    (QUO_W),
        .SB_W  ($bits(cpor_post_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_e_reg),
        .in_num_x  (px_e_reg),
        .in_num_y  (py_e_reg),
        .in_den    (den_e_reg),
        .in_sb     (post_e_reg),
        .out_valid (vld_q),
        .out_quo_x (qx),
        .out_quo_y (qy),
        .out_sb    (post_q)
    );

    assign result.valid        = vld_f_reg;
    assign result.new_first_x  = n1x_reg;
    assign result.new_first_y  = n1y_reg;
    assign result.new_second_x = n2x_reg;
    assign result.new_second_y = n2y_reg;
    assign result.collided     = hit_f_reg;

`ifndef NO_ASSERTIONS
    // a contact always leaves a nonzero overlap to push by
    a_delta_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_d_reg && hit_d_reg |-> delta_d_reg != '0)
        else $error("overlap is zero on a contact");

    // a contact never reaches the divider with a zero divisor
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_e_reg && post_e_reg.hit |-> den_e_reg != '0)
        else $error("zero divisor on a contact");

    // a new result only appears when the divider delivered one
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vld_f_reg) |-> $past(vld_q) && $past(en))
        else $error("result valid without divider output");
`endif

endmodule

`default_nettype wire
